### hdl/ale_pkg.sv
// Shared types and constants for the array list engine.
// No dependencies; imported by ale_ram and array_list_engine.
package ale_pkg;

    // field widths fixed by the word format
    localparam int WORD_W    = 32;
    localparam int POS_W     = 8;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int IN_DATA_W = 40;

    // default capacity of the list
    localparam int ALE_DEPTH = 256;

    // word returned for a read at an unoccupied position
    localparam logic signed [WORD_W-1:0] BAD_READ_WORD = -32'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_INSERT = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_READ_WAIT,
        S_SHIFT,
        S_EMIT
    } t_state;

endpackage

### hdl/ale_ram.sv
// Element store: one write port, one read port with registered read data.
// Depends on ale_pkg for the word width and default depth.
module ale_ram import ale_pkg::*; #(
    parameter int DEPTH = ALE_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/array_list_engine.sv
// Top level of the array list engine: request sequencer, list state and output register.
// Depends on ale_pkg and ale_ram.
//
// Fixed-capacity list of signed 32-bit words kept in a single-port-read memory.
// Each request word (operation in tuser) yields exactly one result word holding
// the returned data, the last stored word, the count and a status in tuser.
// Push writes the memory directly, pop and read make one memory read each, and
// insert at position p into a list of c words moves every entry at or above p
// up one place through the memory's single read and write port; the worst case
// is insert at position 0 of a list holding DEPTH-1 words.
// A result waits in the output register while the next request is accepted;
// a second result waits in the block until that register is free.
module array_list_engine import ale_pkg::*; #(
    parameter int DEPTH = ALE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int OUT_DATA_W = ((2 * WORD_W + CNT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // position[7:0], value[39:8]
    input  logic [OP_W-1:0]       s_axis_tuser,  // operation[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // data_out, top_value, count, zero pad
    output logic [ST_W-1:0]       m_axis_tuser   // status[1:0]
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [WORD_W-1:0]  r_top, n_top;
    logic signed [WORD_W-1:0]  r_res_data, n_res_data;
    t_status                   r_res_status, n_res_status;
    logic [ADDR_W-1:0]         r_pos, n_pos;
    logic signed [WORD_W-1:0]  r_val, n_val;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic [ADDR_W-1:0]         r_wr_addr, n_wr_addr;
    logic                      r_issue, n_issue;
    logic                      r_pend, n_pend;

    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    t_status                   r_out_status;

    logic                      w_we, w_re;
    logic [ADDR_W-1:0]         w_waddr, w_raddr;
    logic [WORD_W-1:0]         w_wdata, w_rdata;

    logic                      w_accept, w_out_free, w_full, w_empty, w_pos_ok;
    t_op                       w_op;
    logic [POS_W-1:0]          w_pos;
    logic signed [WORD_W-1:0]  w_val;

    // input word unpacking and request checks
    assign w_op       = t_op'(s_axis_tuser);
    assign w_pos      = s_axis_tdata[POS_W-1:0];
    assign w_val      = s_axis_tdata[POS_W +: WORD_W];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_pos_ok   = (CMP_W'(w_pos) < CMP_W'(r_count));

    assign s_axis_tready = (r_state == S_IDLE);

    ale_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_PUSH:   n_state = S_EMIT;
                        OP_POP:    n_state = (!w_empty && r_count > CNT_W'(1)) ? S_POP_WAIT
                                                                               : S_EMIT;
                        OP_INSERT: n_state = (w_pos_ok && !w_full) ? S_SHIFT : S_EMIT;
                        OP_READ:   n_state = w_pos_ok ? S_READ_WAIT : S_EMIT;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_POP_WAIT:  n_state = S_EMIT;
            S_READ_WAIT: n_state = S_EMIT;
            S_SHIFT: begin
                if (!r_issue && !r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count      = r_count;
        n_top        = r_top;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_pos        = r_pos;
        n_val        = r_val;
        n_idx        = r_idx;
        n_wr_addr    = r_wr_addr;
        n_issue      = r_issue;
        n_pend       = r_pend;
        w_we         = 1'b0;
        w_waddr      = r_wr_addr;
        w_wdata      = w_rdata;
        w_re         = 1'b0;
        w_raddr      = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pos        = ADDR_W'(w_pos);
                    n_val        = w_val;
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    case (w_op)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = ADDR_W'(r_count);
                                w_wdata = w_val;
                                n_count = r_count + CNT_W'(1);
                                n_top   = w_val;
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_res_data = r_top;
                                n_count    = r_count - CNT_W'(1);
                                if (r_count > CNT_W'(1)) begin
                                    // fetch the new last word
                                    w_re    = 1'b1;
                                    w_raddr = ADDR_W'(r_count - CNT_W'(2));
                                end else begin
                                    n_top = '0;
                                end
                            end
                        end
                        OP_INSERT: begin
                            if (!w_pos_ok) begin
                                n_res_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_idx   = ADDR_W'(r_count - CNT_W'(1));
                                n_issue = 1'b1;
                                n_pend  = 1'b0;
                            end
                        end
                        OP_READ: begin
                            if (!w_pos_ok) begin
                                n_res_data   = BAD_READ_WORD;
                                n_res_status = ST_BADPOS;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = ADDR_W'(w_pos);
                            end
                        end
                        default: n_res_status = ST_OK;
                    endcase
                end
            end
            S_POP_WAIT: begin
                n_top = w_rdata;
            end
            S_READ_WAIT: begin
                n_res_data = w_rdata;
            end
            S_SHIFT: begin
                // write back the word read last cycle one place higher
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_wr_addr;
                    w_wdata = w_rdata;
                end
                if (r_issue) begin
                    w_re      = 1'b1;
                    w_raddr   = r_idx;
                    n_wr_addr = r_idx + ADDR_W'(1);
                    n_pend    = 1'b1;
                    if (r_idx == r_pos) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx - ADDR_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // gap is open: drop the new word in
                        w_we    = 1'b1;
                        w_waddr = r_pos;
                        w_wdata = r_val;
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_EMIT: begin
                n_pend = 1'b0;
            end
            default: begin
                n_issue = 1'b0;
            end
        endcase
    end

    // control and list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            r_issue <= n_issue;
            r_pend  <= n_pend;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_wr_addr    <= n_wr_addr;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data   <= OUT_DATA_W'({r_count, r_top, r_res_data});
            r_out_status <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("list count beyond capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == '0))
        else $error("top word not cleared on empty list");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_PUSH && !w_full) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow the list");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_issue) |-> (r_idx >= r_pos))
        else $error("shift read index passed the insert position");

endmodule
